FILE: rtl/tspt_pkg.sv
// Shared types, constants and handshake structs for the timed setpoint profile table.
package tspt_pkg;

	// Default number of profile segments.
	localparam int DEPTH_DEF = 16;

	// Field widths fixed by the item format.
	localparam int KIND_W = 3;
	localparam int LEN_W  = 16;
	localparam int TIME_W = 20;
	localparam int SP_W   = 16;

	// Largest total duration that the total register holds.
	localparam logic [TIME_W-1:0] TOTAL_MAX = {TIME_W{1'b1}};

	// Setpoint answer for a get that finds no segment.
	localparam logic signed [SP_W-1:0] SP_NONE = -16'sd1;

	// Operation codes.
	typedef enum logic [KIND_W-1:0] {
		KIND_APPEND   = 3'd0,
		KIND_GET      = 3'd1,
		KIND_SET      = 3'd2,
		KIND_ADD      = 3'd3,
		KIND_TIMELEFT = 3'd4
	} kind_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;   // capture the input transaction, clear the search
		logic exec;   // finish append, time left or unknown kind
		logic fetch;  // read the segment at the search index
		logic step;   // advance the search to the next segment
		logic found;  // active segment found at the search index
		logic miss;   // no active segment
	} tspt_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              empty;
		logic              hit;
		logic              last;
	} tspt_stat_t;

endpackage

FILE: rtl/timed_setpoint_profile_table_core.sv
// Top level of the timed setpoint profile table: controller and datapath.
//
// Usage: one input transaction on in_valid/in_ready carries kind, segment_length,
// elapsed_time and setpoint_value; exactly one result transaction on
// out_valid/out_ready carries ok, setpoint_out and remaining_time.
// The block handles one transaction at a time. in_ready is high only while
// the block is idle; it drops at acceptance and rises again after the result
// has been taken.
// Sequence: append, time left and unknown kinds go from decode straight to the
// result. Get, set and add delta walk the segment table through registered reads
// of the segment memories, with a fetch and a check state per segment examined;
// a lookup examines at most DEPTH segments.
// An empty table answers a lookup from decode, without a walk.
// A new transaction is accepted only after the result of the last one has been
// taken, as the controller returns to idle then.
// Reset clears the segment count and the total duration; the segment memories
// are not cleared and are read only below the count.
// When the receiver stalls, the result stays on the outputs, unchanged, and no
// new input is accepted until it is taken.
module timed_setpoint_profile_table_core #(
	parameter int DEPTH = tspt_pkg::DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [tspt_pkg::KIND_W-1:0]      kind,
	input  logic [tspt_pkg::LEN_W-1:0]       segment_length,
	input  logic [tspt_pkg::TIME_W-1:0]      elapsed_time,
	input  logic signed [tspt_pkg::SP_W-1:0] setpoint_value,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             ok,
	output logic signed [tspt_pkg::SP_W-1:0] setpoint_out,
	output logic [tspt_pkg::TIME_W-1:0]      remaining_time
);
	import tspt_pkg::*;

	tspt_cmd_t  cmd;
	tspt_stat_t stat;

	// Sequencer for decode, table walk and result handshake.
	tspt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Segment storage, arithmetic and result registers.
	tspt_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.kind           (kind),
		.segment_length (segment_length),
		.elapsed_time   (elapsed_time),
		.setpoint_value (setpoint_value),
		.cmd            (cmd),
		.stat           (stat),
		.ok             (ok),
		.setpoint_out   (setpoint_out),
		.remaining_time (remaining_time)
	);

endmodule

FILE: rtl/tspt_ctrl.sv
// Controller state machine for the timed setpoint profile table.
module tspt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  tspt_pkg::tspt_stat_t stat,
	output tspt_pkg::tspt_cmd_t  cmd
);
	import tspt_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_DECODE = 5'b00010,
		ST_FETCH  = 5'b00100,
		ST_CHECK  = 5'b01000,
		ST_RESULT = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   lookup;

	// Lookup kinds walk the table; the others go from decode straight to the result.
	always_comb begin
		case (stat.kind)
			KIND_GET, KIND_SET, KIND_ADD: lookup = 1'b1;
			default:                      lookup = 1'b0;
		endcase
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (!lookup) begin
					cmd.exec = 1'b1;
					state_d  = ST_RESULT;
				end else if (stat.empty) begin
					cmd.miss = 1'b1;
					state_d  = ST_RESULT;
				end else begin
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = ST_CHECK;
			end
			ST_CHECK: begin
				if (stat.hit) begin
					cmd.found = 1'b1;
					state_d   = ST_RESULT;
				end else if (stat.last) begin
					cmd.miss = 1'b1;
					state_d  = ST_RESULT;
				end else begin
					cmd.step = 1'b1;
					state_d  = ST_FETCH;
				end
			end
			ST_RESULT: begin
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_RESULT);

endmodule

FILE: rtl/tspt_dp.sv
// Datapath of the timed setpoint profile table: segment memories, totals and result registers.
module tspt_dp #(
	parameter int DEPTH = tspt_pkg::DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [tspt_pkg::KIND_W-1:0]        kind,
	input  logic [tspt_pkg::LEN_W-1:0]         segment_length,
	input  logic [tspt_pkg::TIME_W-1:0]        elapsed_time,
	input  logic signed [tspt_pkg::SP_W-1:0]   setpoint_value,
	input  tspt_pkg::tspt_cmd_t                cmd,
	output tspt_pkg::tspt_stat_t               stat,
	output logic                               ok,
	output logic signed [tspt_pkg::SP_W-1:0]   setpoint_out,
	output logic [tspt_pkg::TIME_W-1:0]        remaining_time
);
	import tspt_pkg::*;

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int END_W = LEN_W + CNT_W;
	localparam int CMP_W = (END_W > TIME_W) ? END_W : TIME_W;
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

	// Segment memories.
	logic [LEN_W-1:0]       dur_mem [DEPTH];
	logic signed [SP_W-1:0] sp_mem  [DEPTH];

	// Captured transaction.
	kind_t                  kind_q;
	logic [LEN_W-1:0]       seglen_q;
	logic [TIME_W-1:0]      elapsed_q;
	logic signed [SP_W-1:0] value_q;

	// Profile state and search state.
	logic [CNT_W-1:0]       count_q;
	logic [TIME_W-1:0]      total_q;
	logic [IDX_W-1:0]       idx_q;
	logic [END_W-1:0]       end_q;
	logic [LEN_W-1:0]       dur_rd_q;
	logic signed [SP_W-1:0] sp_rd_q;

	logic                   full;
	logic                   do_append;
	logic [END_W-1:0]       end_next;
	logic [TIME_W:0]        total_sum;
	logic [TIME_W-1:0]      total_next;
	logic [TIME_W-1:0]      time_left;
	logic signed [SP_W:0]   sp_sum;
	logic signed [SP_W-1:0] sp_sat;
	logic                   sp_we;
	logic [IDX_W-1:0]       sp_waddr;
	logic signed [SP_W-1:0] sp_wdata;

	assign full      = (count_q == DEPTH_C);
	assign do_append = cmd.exec && (kind_q == KIND_APPEND) && !full;

	// Running cumulative end and the strict compare against elapsed time.
	assign end_next   = end_q + END_W'(dur_rd_q);
	assign stat.kind  = kind_q;
	assign stat.empty = (count_q == '0);
	assign stat.hit   = CMP_W'(end_next) > CMP_W'(elapsed_q);
	assign stat.last  = (CNT_W'(idx_q) + CNT_W'(1)) == count_q;

	// Saturating total for append and floored difference for time left.
	assign total_sum  = {1'b0, total_q} + (TIME_W + 1)'(seglen_q);
	assign total_next = total_sum[TIME_W] ? TOTAL_MAX : total_sum[TIME_W-1:0];
	assign time_left  = (elapsed_q > total_q) ? '0 : total_q - elapsed_q;

	// Signed delta added to the found setpoint, clamped to 16 bits.
	always_comb begin
		sp_sum = {sp_rd_q[SP_W-1], sp_rd_q} + {value_q[SP_W-1], value_q};
		if (sp_sum[SP_W] != sp_sum[SP_W-1]) begin
			sp_sat = sp_sum[SP_W] ? {1'b1, {(SP_W-1){1'b0}}} : {1'b0, {(SP_W-1){1'b1}}};
		end else begin
			sp_sat = sp_sum[SP_W-1:0];
		end
	end

	// Setpoint write port: append, set or add delta.
	always_comb begin
		sp_we    = 1'b0;
		sp_waddr = idx_q;
		sp_wdata = value_q;
		if (do_append) begin
			sp_we    = 1'b1;
			sp_waddr = count_q[IDX_W-1:0];
		end else if (cmd.found && (kind_q == KIND_SET)) begin
			sp_we = 1'b1;
		end else if (cmd.found && (kind_q == KIND_ADD)) begin
			sp_we    = 1'b1;
			sp_wdata = sp_sat;
		end
	end

	// Duration memory: written on append, read at the search index.
	always_ff @(posedge clk) begin
		if (do_append) begin
			dur_mem[count_q[IDX_W-1:0]] <= seglen_q;
		end
		if (cmd.fetch) begin
			dur_rd_q <= dur_mem[idx_q];
		end
	end

	// Setpoint memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (sp_we) begin
			sp_mem[sp_waddr] <= sp_wdata;
		end
		if (cmd.fetch) begin
			sp_rd_q <= sp_mem[idx_q];
		end
	end

	// Captured transaction fields.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q    <= kind_t'(kind);
			seglen_q  <= segment_length;
			elapsed_q <= elapsed_time;
			value_q   <= setpoint_value;
		end
	end

	// Search index and running end.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			idx_q <= '0;
			end_q <= '0;
		end else if (cmd.step) begin
			idx_q <= idx_q + IDX_W'(1);
			end_q <= end_next;
		end
	end

	// Segment count and total duration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			total_q <= '0;
		end else if (do_append) begin
			count_q <= count_q + CNT_W'(1);
			total_q <= total_next;
		end
	end

	// Result registers.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			setpoint_out <= '0;
			case (kind_q)
				KIND_APPEND: begin
					ok             <= !full;
					remaining_time <= '0;
				end
				KIND_TIMELEFT: begin
					ok             <= 1'b1;
					remaining_time <= time_left;
				end
				default: begin
					ok             <= 1'b0;
					remaining_time <= '0;
				end
			endcase
		end else if (cmd.found) begin
			ok             <= 1'b1;
			setpoint_out   <= (kind_q == KIND_GET) ? sp_rd_q : '0;
			remaining_time <= '0;
		end else if (cmd.miss) begin
			ok             <= 1'b0;
			setpoint_out   <= (kind_q == KIND_GET) ? SP_NONE : '0;
			remaining_time <= '0;
		end
	end

endmodule
